### hdl/terq_pkg.sv
// ----------------------------------------------------------------------------
// terq_pkg
// Types and codes shared by the timed event release queue.
// ----------------------------------------------------------------------------
package terq_pkg;

  localparam int unsigned QueueDepthDefault = 64;

  localparam int unsigned ScaleWidth  = 24;
  localparam int unsigned WindowWidth = 16;
  localparam int unsigned CfgWidth    = 24;
  localparam int unsigned OffsetWidth = 16;
  localparam int unsigned ProdWidth   = ScaleWidth + OffsetWidth;

  localparam logic [ScaleWidth-1:0]  ScaleReset  = 24'd1486;
  localparam logic [WindowWidth-1:0] WindowReset = 16'd200;

  localparam logic [0:0] CFG_SCALE  = 1'b0;
  localparam logic [0:0] CFG_WINDOW = 1'b1;

  localparam logic [1:0] MODE_ENQUEUE = 2'd0;
  localparam logic [1:0] MODE_TICK    = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;

  localparam logic [1:0] KIND_SENT    = 2'd0;
  localparam logic [1:0] KIND_STALE   = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] start_ms;
    logic [15:0] sample_offset;
    logic [23:0] msg_bytes;
    logic [1:0]  msg_len;
    logic [31:0] now_ms;
  } terq_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] out_bytes;
    logic [1:0]  out_len;
    logic [31:0] event_ms;
  } terq_out_t;

  typedef struct packed {
    logic [31:0] event_ms;
    logic [23:0] msg_bytes;
    logic [1:0]  msg_len;
  } terq_entry_t;

  typedef struct packed {
    logic        insert;
    logic        pop;
    logic        clear;
    terq_entry_t new_entry;
  } terq_cell_ctl_t;

endpackage

### hdl/terq_time.sv
// ----------------------------------------------------------------------------
// terq_time
// Two-stage release time calculation: scale product, then rounding and add.
// ----------------------------------------------------------------------------
module terq_time
  import terq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  logic                  in_valid_i,
  input  terq_in_t              in_data_i,
  input  logic [ScaleWidth-1:0] scale_i,
  output logic                  act_valid_o,
  output terq_in_t              act_data_o,
  output logic [31:0]           act_ms_o
);

  logic                 mul_valid_q;
  terq_in_t             mul_data_q;
  logic [ProdWidth-1:0] prod_q;
  logic                 act_valid_q;
  terq_in_t             act_data_q;
  logic [31:0]          act_ms_q;
  logic [ProdWidth:0]   rounded;
  logic [31:0]          act_ms_d;

  always_comb begin
    rounded  = {1'b0, prod_q} + (ProdWidth+1)'(32768);
    act_ms_d = mul_data_q.start_ms + 32'(rounded[ProdWidth:16]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      act_valid_q <= 1'b0;
    end else if (advance_i) begin
      mul_valid_q <= in_valid_i;
      act_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      mul_data_q <= in_data_i;
      prod_q     <= ProdWidth'(scale_i) * ProdWidth'(in_data_i.sample_offset);
      act_data_q <= mul_data_q;
      act_ms_q   <= act_ms_d;
    end
  end

  assign act_valid_o = act_valid_q;
  assign act_data_o  = act_data_q;
  assign act_ms_o    = act_ms_q;

endmodule

### hdl/terq_cell.sv
// ----------------------------------------------------------------------------
// terq_cell
// One slot of the sorted queue; shifts toward or away from the head.
// ----------------------------------------------------------------------------
module terq_cell
  import terq_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  terq_cell_ctl_t ctl_i,
  input  logic           prev_valid_i,
  input  terq_entry_t    prev_entry_i,
  input  logic           prev_before_i,
  input  logic           next_valid_i,
  input  terq_entry_t    next_entry_i,
  output logic           valid_o,
  output terq_entry_t    entry_o,
  output logic           before_o
);

  logic        valid_q, valid_d;
  terq_entry_t entry_q, entry_d;
  logic        ahead;

  // The new entry goes at or ahead of this slot when the slot is empty or later.
  assign ahead = !valid_q || (entry_q.event_ms > ctl_i.new_entry.event_ms);

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    priority if (ctl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctl_i.pop) begin
      valid_d = next_valid_i;
      entry_d = next_entry_i;
    end else if (ctl_i.insert && ahead) begin
      if (prev_before_i) begin
        valid_d = prev_valid_i;
        entry_d = prev_entry_i;
      end else begin
        valid_d = 1'b1;
        entry_d = ctl_i.new_entry;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o  = valid_q;
  assign entry_o  = entry_q;
  assign before_o = ahead;

endmodule

### hdl/timed_event_release_queue.sv
// ----------------------------------------------------------------------------
// timed_event_release_queue
// Time-sorted queue of short messages, built as a chain of shifting cells.
//
//   Port group    Direction  Handshake            Payload
//   in_*          input      in_valid_i/in_stall_o  terq_in_t
//   out_*         output     out_valid_o/out_stall_i terq_out_t
//   cfg_*         input      cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// One transaction is accepted per cycle unless a held output result is stalled.
// Its result, if any, passes the multiply register and the round-and-add
// register and is then loaded into the output register together with the cell
// update. A stall on a held output result freezes the whole pipeline. Reset
// empties the queue and loads the default scale and stale window.
// ----------------------------------------------------------------------------
module timed_event_release_queue
  import terq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  terq_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output terq_out_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i
);

  logic [ScaleWidth-1:0]  scale_q;
  logic [WindowWidth-1:0] window_q;
  logic                   advance;
  logic                   act_valid;
  terq_in_t               act_data;
  logic [31:0]            act_ms;
  logic                   act_fire;
  logic                   full;
  logic                   due;
  logic                   stale;
  logic [32:0]            stale_limit;
  logic                   reject;
  terq_cell_ctl_t         ctl;
  logic                   out_valid_q, out_valid_d;
  terq_out_t              out_q, out_d;

  logic        cell_valid  [QUEUE_DEPTH];
  terq_entry_t cell_entry  [QUEUE_DEPTH];
  logic        cell_before [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] valid_vec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= ScaleReset;
      window_q <= WindowReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCALE:  scale_q  <= cfg_wdata_i[ScaleWidth-1:0];
        CFG_WINDOW: window_q <= cfg_wdata_i[WindowWidth-1:0];
        default:    scale_q  <= scale_q;
      endcase
    end
  end

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !advance;

  terq_time u_time (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .scale_i     (scale_q),
    .act_valid_o (act_valid),
    .act_data_o  (act_data),
    .act_ms_o    (act_ms)
  );

  assign act_fire    = act_valid && advance;
  assign full        = cell_valid[QUEUE_DEPTH-1];
  assign due         = cell_valid[0] && (cell_entry[0].event_ms <= act_data.now_ms);
  assign stale_limit = {1'b0, act_data.now_ms} - {17'd0, window_q};
  assign stale       = !stale_limit[32] && (cell_entry[0].event_ms <= stale_limit[31:0]);
  assign reject      = (act_data.mode == MODE_ENQUEUE) && full;

  always_comb begin
    ctl.insert              = act_fire && (act_data.mode == MODE_ENQUEUE) && !full;
    ctl.pop                 = act_fire && (act_data.mode == MODE_TICK) && due;
    ctl.clear               = act_fire && (act_data.mode == MODE_CLEAR);
    ctl.new_entry.event_ms  = act_ms;
    ctl.new_entry.msg_bytes = act_data.msg_bytes;
    ctl.new_entry.msg_len   = act_data.msg_len;
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic        prev_valid;
    terq_entry_t prev_entry;
    logic        prev_before;
    logic        next_valid;
    terq_entry_t next_entry;

    if (i == 0) begin : g_head
      assign prev_valid  = 1'b0;
      assign prev_entry  = '0;
      assign prev_before = 1'b0;
    end else begin : g_body
      assign prev_valid  = cell_valid[i-1];
      assign prev_entry  = cell_entry[i-1];
      assign prev_before = cell_before[i-1];
    end

    if (i == QUEUE_DEPTH-1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_entry = '0;
    end else begin : g_link
      assign next_valid = cell_valid[i+1];
      assign next_entry = cell_entry[i+1];
    end

    terq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .prev_valid_i  (prev_valid),
      .prev_entry_i  (prev_entry),
      .prev_before_i (prev_before),
      .next_valid_i  (next_valid),
      .next_entry_i  (next_entry),
      .valid_o       (cell_valid[i]),
      .entry_o       (cell_entry[i]),
      .before_o      (cell_before[i])
    );

    assign valid_vec[i] = cell_valid[i];
  end

  always_comb begin
    out_valid_d = 1'b0;
    out_d       = out_q;
    if (act_valid) begin
      if (reject) begin
        out_valid_d     = 1'b1;
        out_d.kind      = KIND_REJECT;
        out_d.out_bytes = act_data.msg_bytes;
        out_d.out_len   = act_data.msg_len;
        out_d.event_ms  = act_ms;
      end else if ((act_data.mode == MODE_TICK) && due) begin
        out_valid_d     = 1'b1;
        out_d.kind      = stale ? KIND_STALE : KIND_SENT;
        out_d.out_bytes = cell_entry[0].msg_bytes;
        out_d.out_len   = cell_entry[0].msg_len;
        out_d.event_ms  = cell_entry[0].event_ms;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Occupied cells always form a contiguous run starting at the head.
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + QUEUE_DEPTH'(1))) == '0)
    else $error("queue cells are not packed toward the head");

  a_sorted_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[1] |-> (cell_entry[0].event_ms <= cell_entry[1].event_ms))
    else $error("queue head is later than its successor");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.clear |=> (valid_vec == '0))
    else $error("clear left cells occupied");

  a_reject_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_fire && reject) |=> (out_valid_q && (out_q.kind == KIND_REJECT)
      && ($past(valid_vec) == valid_vec)))
    else $error("full enqueue not rejected cleanly");

endmodule
